### rtl/fba_pkg.sv
// Shared types and constants of the frame bitmap allocator.
// Depends on nothing; used by frame_bitmap_allocator.
package fba_pkg;

	localparam int CUR_FRAME_W     = 12;
	localparam int FRAME_IDX_W     = 12;
	localparam int FRAME_COUNT_W   = 13;
	localparam int FRAME_COUNT_RST = 4096;
	localparam int APB_DATA_W      = 32;
	localparam int APB_ADDR_W      = 3;
	localparam int S_TDATA_W       = 16;
	localparam int M_TDATA_W       = 24;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_COUNT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} fba_state_t;

	typedef struct packed {
		logic                   out_of_frames;
		logic [FRAME_IDX_W-1:0] frame_index;
		logic                   user_bit;
		logic                   writable_bit;
		logic                   present_bit;
		logic                   allocated;
	} fba_res_t;

endpackage

### rtl/frame_bitmap_allocator.sv
// Frame bitmap allocator: first-fit frame allocation over a used-frame bitmap memory.
// Depends on fba_pkg for types and constants.
//
// Usage:
//   s_* stream: one request per accepted item; tdata carries current_frame,
//   kernel_page and write_allowed. m_* stream: exactly one result per request,
//   in request order. APB port: register 0 (byte address 0) is frame_count.
//   A request with a nonzero current_frame, or with no whole word to search,
//   goes from ST_IDLE straight to ST_EMIT with no scan. Otherwise the
//   bitmap memory is read one word per cycle from word 0, up to
//   min(frame_count / WORD_BITS, MAX_FRAMES / WORD_BITS) words; the first word
//   with a clear bit is marked and written back. Words are read through the
//   single memory read port. One request is worked on at a time; s_tready is
//   high whenever no request is in progress.
// Reset: every frame is free (per-word valid bits are cleared at once, no
//   clearing pass), frame_count is 4096, no result is pending.
// Stall: a result waits in the output register while m_tready is low; one
//   further request is still taken and searched, then waits in ST_EMIT.
module frame_bitmap_allocator #(
	parameter int MAX_FRAMES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata: current_frame[11:0], kernel_page[12], write_allowed[13], zero[15:14]
	input  logic [fba_pkg::S_TDATA_W-1:0]       s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata: allocated[0], present_bit[1], writable_bit[2], user_bit[3],
	//        frame_index[15:4], out_of_frames[16], zero[23:17]
	output logic [fba_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fba_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [fba_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [fba_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int MAP_WORDS = MAX_FRAMES / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CW        = $clog2(MAP_WORDS + 1);
	localparam int WB_LOG    = $clog2(WORD_BITS);
	localparam int FCW       = fba_pkg::FRAME_COUNT_W;

	fba_pkg::fba_state_t state_q, state_d;

	logic [FCW-1:0]                   frame_count_q;
	logic [CW-1:0]                    words;
	logic [FCW-1:0]                   words_raw;
	logic [CW-1:0]                    iss_q;
	logic                             rd_vld_s1;
	logic [AW-1:0]                    rd_idx_s1;
	logic [WORD_BITS-1:0]             rdata_s1;
	logic                             vbit_s1;
	logic [WORD_BITS-1:0]             seen_word;
	logic [WB_LOG-1:0]                bit_sel;
	logic [MAP_WORDS-1:0]             vld_q;
	logic [WORD_BITS-1:0]             map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0]             wr_data;
	logic                             kern_q;
	logic                             wr_q;
	fba_pkg::fba_res_t                res_q;
	fba_pkg::fba_res_t                out_q;
	logic                             out_vld_q;

	logic                             s_acc;
	logic                             cfg_wr;
	logic                             iss_en;
	logic                             found;
	logic                             exhaust;
	logic                             emit;
	logic [fba_pkg::CUR_FRAME_W-1:0]  cur_frame;

	assign cur_frame = s_tdata[fba_pkg::CUR_FRAME_W-1:0];
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == fba_pkg::REG_FRAME_COUNT) ?
		fba_pkg::APB_DATA_W'(frame_count_q) : '0;

	// searched word count, saturated at the map size
	always_comb begin
		words_raw = frame_count_q >> WB_LOG;
		if (32'(words_raw) > 32'(MAP_WORDS)) begin
			words = CW'(MAP_WORDS);
		end else begin
			words = CW'(words_raw);
		end
	end

	// lowest clear bit of the word just read
	always_comb begin
		seen_word = vbit_s1 ? rdata_s1 : '0;
		bit_sel   = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (!seen_word[k]) begin
				bit_sel = WB_LOG'(k);
			end
		end
		wr_data = seen_word | (WORD_BITS'(1) << bit_sel);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fba_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (cur_frame != '0 || words == '0) begin
						state_d = fba_pkg::ST_EMIT;
					end else begin
						state_d = fba_pkg::ST_SCAN;
					end
				end
			end
			fba_pkg::ST_SCAN: begin
				if (found || exhaust) begin
					state_d = fba_pkg::ST_EMIT;
				end
			end
			fba_pkg::ST_EMIT: begin
				if (emit) begin
					state_d = fba_pkg::ST_IDLE;
				end
			end
			default: state_d = fba_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		iss_en   = 1'b0;
		found    = 1'b0;
		exhaust  = 1'b0;
		emit     = 1'b0;
		case (state_q)
			fba_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			fba_pkg::ST_SCAN: begin
				found   = rd_vld_s1 && (seen_word != '1);
				iss_en  = !found && (iss_q < words);
				exhaust = !rd_vld_s1 && (iss_q >= words);
			end
			fba_pkg::ST_EMIT: begin
				emit = !out_vld_q || m_tready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fba_pkg::ST_IDLE;
			frame_count_q <= FCW'(fba_pkg::FRAME_COUNT_RST);
			iss_q         <= '0;
			rd_vld_s1     <= 1'b0;
			vld_q         <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= iss_en;
			if (cfg_wr && paddr[2] == fba_pkg::REG_FRAME_COUNT) begin
				frame_count_q <= pwdata[FCW-1:0];
			end
			if (s_acc) begin
				iss_q <= '0;
			end else if (iss_en) begin
				iss_q <= iss_q + CW'(1);
			end
			if (found) begin
				vld_q[rd_idx_s1] <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// bitmap memory: one read and one write port
	always_ff @(posedge clk) begin
		if (found) begin
			map_mem[rd_idx_s1] <= wr_data;
		end
		if (iss_en) begin
			rdata_s1  <= map_mem[iss_q[AW-1:0]];
			vbit_s1   <= vld_q[iss_q[AW-1:0]];
			rd_idx_s1 <= iss_q[AW-1:0];
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kern_q <= s_tdata[fba_pkg::CUR_FRAME_W];
			wr_q   <= s_tdata[fba_pkg::CUR_FRAME_W+1];
			res_q  <= '{out_of_frames: (cur_frame == '0), default: '0};
		end else if (found) begin
			res_q.allocated     <= 1'b1;
			res_q.present_bit   <= 1'b1;
			res_q.writable_bit  <= wr_q;
			res_q.user_bit      <= !kern_q;
			res_q.frame_index   <= fba_pkg::FRAME_IDX_W'({rd_idx_s1, bit_sel});
			res_q.out_of_frames <= 1'b0;
		end else if (exhaust) begin
			res_q.out_of_frames <= 1'b1;
		end
		if (emit) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = fba_pkg::M_TDATA_W'(out_q);

`ifndef ASSERT_OFF
	a_alloc_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[16] && m_tdata[1])
		else $error("allocated result also flags exhaustion");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fba_pkg::ST_SCAN |-> iss_q <= words)
		else $error("scan issued past the searched word count");
	a_mapped_skip: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && cur_frame != '0 |=> state_q == fba_pkg::ST_EMIT)
		else $error("mapped request started a scan");
`endif

endmodule
